>>> sv/euler_xyz_pointing_vector_core_macros.svh
// Assertion macros shared by the pointing vector core.
// Used by files that assert; each macro expects a clock named aclk and reset aresetn.
`ifndef EULER_XYZ_POINTING_VECTOR_CORE_MACROS_SVH
`define EULER_XYZ_POINTING_VECTOR_CORE_MACROS_SVH

// Checked only while out of reset.
`define EXPV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define EXPV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/expv_pkg.sv
// Shared types, constants and the arctangent table of the pointing vector core.
// No dependencies.
`timescale 1ns / 1ps

package expv_pkg;

    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int ANGLE_W = 25;
    localparam int OUT_W   = 18;
    localparam int Q30_W   = 32;
    localparam int CW      = 34;
    localparam int PH_W    = 32;

    // Angle wrap and conversion of degrees to a 32-bit binary phase.
    localparam logic [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(360 << ANGLE_FRAC_BITS);
    localparam int PHASE_SHIFT = 29 - ANGLE_FRAC_BITS;
    localparam int PH_DIV      = 45;
    localparam int PH_RND      = 22;
    localparam logic [25:0] RECIP45 = 26'd47721859;
    localparam int RECIP_SHIFT = 31;
    localparam int QUO_W = 19;
    localparam int REM_W = 6;
    localparam int TBL_W = 13;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [PH_W-1:0] z;
        quad_t                  quad;
    } cordic_t;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn.
    function automatic logic [PH_W-1:0] atan_turn(input int i);
        logic [PH_W-1:0] v;
        case (i)
            0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
            27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> sv/euler_xyz_pointing_vector_core.sv
// Pointing vector from three XYZ rotation angles.
// Input word: s_tdata carries angle_x_deg, angle_y_deg and angle_z_deg, 25-bit signed
// degrees with 16 fractional bits. Result word: m_tdata carries dir_x, dir_y and dir_z,
// 18-bit signed components of the rotated (0,0,-1) vector, saturated to plus or minus one.
// Each angle is wrapped to one turn, converted to a binary phase and fed through a row of
// CORDIC cells, one cell per stage; the sine/cosine pairs then go through two multiplier
// ranks and are rounded into the output register.
// One word is accepted per cycle while the skid register is empty; the rate is set by
// the pipeline enable, which moves every stage at once.
// When the receiver stalls, one more word lands in a skid register and s_tready then
// drops until the output register frees up; no word is lost or repeated.
// Reset clears the stage valid bits and the valid bits of the output and skid registers;
// their data and the data path itself are not reset.
// Depends on expv_pkg, expv_sincos, expv_cell, expv_mix and the assertion macros header.
`timescale 1ns / 1ps
`include "euler_xyz_pointing_vector_core_macros.svh"

module euler_xyz_pointing_vector_core #(
    parameter int OUT_FRAC_BITS = expv_pkg::OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = expv_pkg::CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // angle_x_deg [24:0], angle_y_deg [49:25], angle_z_deg [74:50]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // dir_x [17:0], dir_y [35:18], dir_z [53:36]
);

    localparam int AW    = expv_pkg::ANGLE_W;
    localparam int OWF   = expv_pkg::OUT_W;
    localparam int DEPTH = CORDIC_STAGES + 5;
    localparam logic signed [OWF:0] OUT_LIM = (OWF+1)'(1) << OUT_FRAC_BITS;

    logic                              en_pipe;
    logic [DEPTH-1:0]                  valid_reg, valid_next;
    logic signed [expv_pkg::Q30_W-1:0] sx, cx, sy, cy, sz, cz;
    logic [OWF-1:0]                    fin_x, fin_y, fin_z;
    logic [3*OWF-1:0]                  fin_word;
    logic                              out_valid_reg, out_valid_next;
    logic [3*OWF-1:0]                  out_data_reg, out_data_next;
    logic                              skid_valid_reg, skid_valid_next;
    logic [3*OWF-1:0]                  skid_data_reg, skid_data_next;
    logic signed [OWF:0]               dir_x_chk;
    logic                              dir_x_in_range;

    // The whole pipeline moves while the skid register is empty.
    assign en_pipe    = !skid_valid_reg;
    assign s_tready   = en_pipe;
    assign valid_next = {valid_reg[DEPTH-2:0], s_tvalid};

    expv_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_x (
        .aclk(aclk), .en(en_pipe), .angle($signed(s_tdata[AW-1:0])),
        .sin_q30(sx), .cos_q30(cx)
    );
    expv_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_y (
        .aclk(aclk), .en(en_pipe), .angle($signed(s_tdata[2*AW-1:AW])),
        .sin_q30(sy), .cos_q30(cy)
    );
    expv_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_z (
        .aclk(aclk), .en(en_pipe), .angle($signed(s_tdata[3*AW-1:2*AW])),
        .sin_q30(sz), .cos_q30(cz)
    );

    expv_mix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mix (
        .aclk(aclk), .en(en_pipe),
        .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
        .fin_x(fin_x), .fin_y(fin_y), .fin_z(fin_z)
    );

    assign fin_word = {fin_z, fin_y, fin_x};

    // Output register with a skid stage behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !m_tready) begin
            if (valid_reg[DEPTH-1] && en_pipe) begin
                skid_valid_next = 1'b1;
                skid_data_next  = fin_word;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = valid_reg[DEPTH-1];
            out_data_next  = fin_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en_pipe) begin
                valid_reg <= valid_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    assign dir_x_chk      = $signed({out_data_reg[OWF-1], out_data_reg[OWF-1:0]});
    assign dir_x_in_range = (dir_x_chk <= OUT_LIM) && (dir_x_chk >= -OUT_LIM);

    // A held word in the skid register always sits behind a full output register.
    `EXPV_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid full, output empty")
    // With the output register empty the input side must be open.
    `EXPV_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")
    // A word in the skid register stays there while the receiver stalls.
    `EXPV_ASSERT(a_skid_holds, skid_valid_reg && !m_tready |=> skid_valid_reg, "skid word lost")
    // Nothing comes out in the cycle after reset.
    `EXPV_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "output valid after reset")
    // dir_x stays within plus or minus one while OUT_FRAC_BITS is at most 16.
    `EXPV_ASSERT(a_dir_range, m_tvalid && (OUT_FRAC_BITS <= 16) |-> dir_x_in_range, "dir_x range")

endmodule

>>> sv/expv_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation per clock while en is high.
// Depends on expv_pkg.
`timescale 1ns / 1ps

module expv_cell #(
    parameter int STAGE = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  expv_pkg::cordic_t din,
    output expv_pkg::cordic_t dout
);

    localparam logic signed [expv_pkg::PH_W-1:0] ATAN = expv_pkg::atan_turn(STAGE);

    expv_pkg::cordic_t stage_reg, stage_next;
    logic signed [expv_pkg::CW-1:0] dx, dy;

    // Shifted cross terms; the sign of the residual angle picks the direction.
    always_comb begin
        dx = din.y >>> STAGE;
        dy = din.x >>> STAGE;
        stage_next = din;
        if (!din.z[expv_pkg::PH_W-1]) begin
            stage_next.x = din.x - dx;
            stage_next.y = din.y + dy;
            stage_next.z = din.z - ATAN;
        end else begin
            stage_next.x = din.x + dx;
            stage_next.y = din.y - dy;
            stage_next.z = din.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign dout = stage_reg;

endmodule

>>> sv/expv_sincos.sv
// Sine and cosine of one angle: wrap, phase conversion, fold and a chain of CORDIC cells.
// Depends on expv_pkg and expv_cell.
`timescale 1ns / 1ps

module expv_sincos #(
    parameter int CORDIC_STAGES = expv_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [expv_pkg::ANGLE_W-1:0] angle,
    output logic signed [expv_pkg::Q30_W-1:0]   sin_q30,
    output logic signed [expv_pkg::Q30_W-1:0]   cos_q30
);

    localparam int AW = expv_pkg::ANGLE_W;

    logic [AW-1:0]                r0_reg, r0_next;
    logic [AW-1:0]                r1_reg;
    logic [expv_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [expv_pkg::PH_W-1:0]    phase_reg, phase_next;
    logic [AW+25:0]               recip_prod;
    logic [AW-1:0]                rem_wide;
    logic [expv_pkg::REM_W-1:0]   rem;
    logic [expv_pkg::TBL_W-1:0]   rem_tbl [expv_pkg::PH_DIV];
    logic [expv_pkg::PH_W-1:0]    ph_rnd;
    expv_pkg::cordic_t            chain [CORDIC_STAGES+1];
    expv_pkg::cordic_t            last;

    // Phase of each remainder of the division by the phase divisor.
    for (genvar g = 0; g < expv_pkg::PH_DIV; g++) begin : g_rem_tbl
        assign rem_tbl[g] = expv_pkg::TBL_W'(
            ((1 << expv_pkg::PHASE_SHIFT) * g + expv_pkg::PH_RND) / expv_pkg::PH_DIV);
    end

    // Wrap into one turn; a single add suffices as the field is under one turn.
    always_comb begin
        if (angle[AW-1]) begin
            r0_next = AW'($signed({angle[AW-1], angle}) + $signed({1'b0, expv_pkg::ANGLE_FULL}));
        end else begin
            r0_next = angle;
        end
    end

    // Quotient by the divisor through a reciprocal product.
    assign recip_prod = (AW+26)'(r0_reg) * (AW+26)'(expv_pkg::RECIP45);
    assign quo_next   = recip_prod[expv_pkg::RECIP_SHIFT +: expv_pkg::QUO_W];

    // Remainder selects the fractional part of the phase.
    assign rem_wide   = r1_reg - AW'(quo_reg * AW'(expv_pkg::PH_DIV));
    assign rem        = rem_wide[expv_pkg::REM_W-1:0];
    assign phase_next = expv_pkg::PH_W'({quo_reg, {expv_pkg::PHASE_SHIFT{1'b0}}})
                        + expv_pkg::PH_W'(rem_tbl[rem]);

    always_ff @(posedge aclk) begin
        if (en) begin
            r0_reg    <= r0_next;
            r1_reg    <= r0_reg;
            quo_reg   <= quo_next;
            phase_reg <= phase_next;
        end
    end

    // Quadrant fold leaves a residual within plus or minus an eighth turn.
    assign ph_rnd = phase_reg + 32'h2000_0000;
    always_comb begin
        chain[0].quad = expv_pkg::quad_t'(ph_rnd[31:30]);
        chain[0].z    = $signed(phase_reg - {ph_rnd[31:30], 30'b0});
        chain[0].x    = expv_pkg::CORDIC_GAIN;
        chain[0].y    = '0;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        expv_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk (aclk),
            .en   (en),
            .din  (chain[g]),
            .dout (chain[g+1])
        );
    end

    // Undo the quadrant fold by swaps and negations.
    assign last = chain[CORDIC_STAGES];
    always_comb begin
        unique case (last.quad)
            expv_pkg::QUAD_0: begin
                cos_q30 = expv_pkg::Q30_W'(last.x);
                sin_q30 = expv_pkg::Q30_W'(last.y);
            end
            expv_pkg::QUAD_90: begin
                cos_q30 = expv_pkg::Q30_W'(-last.y);
                sin_q30 = expv_pkg::Q30_W'(last.x);
            end
            expv_pkg::QUAD_180: begin
                cos_q30 = expv_pkg::Q30_W'(-last.x);
                sin_q30 = expv_pkg::Q30_W'(-last.y);
            end
            expv_pkg::QUAD_270: begin
                cos_q30 = expv_pkg::Q30_W'(last.y);
                sin_q30 = expv_pkg::Q30_W'(-last.x);
            end
        endcase
    end

endmodule

>>> sv/expv_mix.sv
// Rotation products of the three sine/cosine pairs and output scaling.
// Depends on expv_pkg.
`timescale 1ns / 1ps

module expv_mix #(
    parameter int OUT_FRAC_BITS = expv_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [expv_pkg::Q30_W-1:0] sx,
    input  logic signed [expv_pkg::Q30_W-1:0] cx,
    input  logic signed [expv_pkg::Q30_W-1:0] sy,
    input  logic signed [expv_pkg::Q30_W-1:0] cy,
    input  logic signed [expv_pkg::Q30_W-1:0] sz,
    input  logic signed [expv_pkg::Q30_W-1:0] cz,
    output logic [expv_pkg::OUT_W-1:0]        fin_x,
    output logic [expv_pkg::OUT_W-1:0]        fin_y,
    output logic [expv_pkg::OUT_W-1:0]        fin_z
);

    localparam int QW = expv_pkg::Q30_W;
    localparam int OW = 35;
    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [OW-1:0] RND = (SH > 0) ? OW'(1) << (SH - 1) : '0;
    localparam logic signed [OW-1:0] LIM = OW'(1) << OUT_FRAC_BITS;

    logic signed [QW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, cz1_reg, sz1_reg;
    logic signed [QW-1:0] p5_reg, p6_reg, p3b_reg, p4b_reg, p2b_reg;
    logic signed [QW-1:0] t;

    // Q30 by Q30, rounded half up back to Q30.
    function automatic logic signed [QW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                       input logic signed [QW-1:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return QW'(p >>> 30);
    endfunction

    // Round to the output scale, saturate to plus or minus one, keep the field bits.
    function automatic logic [expv_pkg::OUT_W-1:0] to_out(input logic signed [QW:0] v);
        logic signed [OW-1:0] o;
        o = (OW'(v) + RND) >>> SH;
        if (o > LIM) begin
            o = LIM;
        end else if (o < -LIM) begin
            o = -LIM;
        end
        return o[expv_pkg::OUT_W-1:0];
    endfunction

    assign t = -p1_reg;

    // First product rank, then the products that use the negated sy*cx term.
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= mul_q30(sy, cx);
            p2_reg  <= mul_q30(cy, cx);
            p3_reg  <= mul_q30(sz, sx);
            p4_reg  <= mul_q30(cz, sx);
            cz1_reg <= cz;
            sz1_reg <= sz;
            p5_reg  <= mul_q30(cz1_reg, t);
            p6_reg  <= mul_q30(sz1_reg, t);
            p3b_reg <= p3_reg;
            p4b_reg <= p4_reg;
            p2b_reg <= p2_reg;
        end
    end

    // Final sums feed the output register in the top level.
    assign fin_x = to_out((QW+1)'(p5_reg) - (QW+1)'(p3b_reg));
    assign fin_y = to_out((QW+1)'(p6_reg) + (QW+1)'(p4b_reg));
    assign fin_z = to_out(-(QW+1)'(p2b_reg));

endmodule
